// File: rtl/wav_header_parser_assert.svh
// Assertion macros shared by the WAV header parser RTL.
// Expects i_clk and i_rst_n in the including module; no other dependencies.
`ifndef WAV_HEADER_PARSER_ASSERT_SVH
`define WAV_HEADER_PARSER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define WAVHP_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define WAVHP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/wavhp_pkg.sv
// Shared types, constants and helpers for the WAV header parser.
// No dependencies; used by every RTL file of the block.
package wavhp_pkg;

    // Header layout
    localparam int HDR_LEN     = 44;
    localparam int IDX_W       = 6;
    localparam int OFS_RIFF    = 0;
    localparam int OFS_WAVE    = 8;
    localparam int OFS_FORMAT  = 20;
    localparam int OFS_CHAN    = 22;
    localparam int OFS_RATE    = 24;
    localparam int OFS_BITS    = 34;
    localparam int OFS_SIZE    = 40;

    localparam logic [IDX_W-1:0] HDR_END  = IDX_W'(HDR_LEN);
    localparam logic [IDX_W-1:0] LAST_OFS = IDX_W'(HDR_LEN - 1);

    localparam logic [31:0] RIFF_TAG   = "RIFF";
    localparam logic [31:0] WAVE_TAG   = "WAVE";
    localparam logic [15:0] PCM_FORMAT = 16'h0001;

    // Duration math: size * 1000 needs 42 bits, one quotient bit per step
    localparam int SCALED_W  = 42;
    localparam int DIV_STEPS = SCALED_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);
    localparam logic [SCALED_W-1:0] MS_PER_S = SCALED_W'(1000);

    // Job queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_TRUNC     = 2'd1;
    localparam logic [1:0] ST_BAD_MAGIC = 2'd2;
    localparam logic [1:0] ST_NOT_PCM   = 2'd3;

    typedef struct packed {
        logic [7:0] header_byte;
        logic       first_of_header;
        logic       stream_ended;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  parse_status;
        logic [15:0] channel_count;
        logic [31:0] sample_hz;
        logic [15:0] sample_bits;
        logic [31:0] payload_bytes;
        logic [31:0] byte_rate;
        logic [31:0] duration_ms;
    } t_out_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] channels;
        logic [31:0] rate;
        logic [15:0] bits;
        logic [31:0] size;
    } t_job;

    typedef struct packed {
        logic valid;
        t_job job;
    } t_qpush;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL1,
        BK_MUL2,
        BK_DIV,
        BK_DONE
    } t_back_state;

    // Byte k (file order) of a four-character tag
    function automatic logic [7:0] tag_byte(input logic [31:0] tag, input logic [1:0] k);
        return tag[{~k, 3'b000} +: 8];
    endfunction

endpackage

// File: rtl/wavhp_queue.sv
// Two-entry job queue between the parser front and the arithmetic back.
// Depends on wavhp_pkg and wav_header_parser_assert.svh.
`include "wav_header_parser_assert.svh"

module wavhp_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  wavhp_pkg::t_qpush i_push,
    input  logic              i_pop,
    output wavhp_pkg::t_job   o_head,
    output logic              o_empty,
    output logic              o_full
);

    wavhp_pkg::t_job                 r_mem [wavhp_pkg::QDEPTH];
    logic [wavhp_pkg::QPTR_W-1:0]    r_wptr;
    logic [wavhp_pkg::QPTR_W-1:0]    r_rptr;
    logic [wavhp_pkg::QCNT_W-1:0]    r_cnt;
    logic [wavhp_pkg::QPTR_W-1:0]    n_wptr;
    logic [wavhp_pkg::QPTR_W-1:0]    n_rptr;
    logic [wavhp_pkg::QCNT_W-1:0]    n_cnt;

    localparam logic [wavhp_pkg::QPTR_W-1:0] PTR_LAST = wavhp_pkg::QPTR_W'(wavhp_pkg::QDEPTH - 1);
    localparam logic [wavhp_pkg::QCNT_W-1:0] CNT_FULL = wavhp_pkg::QCNT_W'(wavhp_pkg::QDEPTH);

    assign o_head  = r_mem[r_rptr];
    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CNT_FULL);

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (i_push.valid) begin
            n_wptr = (r_wptr == PTR_LAST) ? '0 : r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = (r_rptr == PTR_LAST) ? '0 : r_rptr + 1'b1;
        end
        if (i_push.valid && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push.valid && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wptr] <= i_push.job;
        end
    end

    `WAVHP_ASSERT_SAME(a_q_no_overflow, i_push.valid, r_cnt != CNT_FULL, "job pushed into full queue")
    `WAVHP_ASSERT_SAME(a_q_no_underflow, i_pop, r_cnt != '0, "job popped from empty queue")

endmodule

// File: rtl/wavhp_front.sv
// Parser front: counts header bytes, checks magic, captures header words
// and queues one job per finished or truncated header. Depends on wavhp_pkg.
module wavhp_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  wavhp_pkg::t_in_item  i_in_item,
    output logic                 o_in_stall,
    input  logic                 i_q_full,
    output wavhp_pkg::t_qpush    o_push
);

    logic [wavhp_pkg::IDX_W-1:0] r_idx;
    logic                        r_magic;
    logic [15:0]                 r_format;
    logic [15:0]                 r_chan;
    logic [31:0]                 r_rate;
    logic [15:0]                 r_bits;
    logic [31:0]                 r_size;

    logic [wavhp_pkg::IDX_W-1:0] n_idx;
    logic                        n_magic;
    logic [15:0]                 n_format;
    logic [15:0]                 n_chan;
    logic [31:0]                 n_rate;
    logic [15:0]                 n_bits;
    logic [31:0]                 n_size;

    logic                        w_accept;
    logic [wavhp_pkg::IDX_W-1:0] w_pos;
    logic [7:0]                  w_byte;

    // Only stall when there is no room for a job
    assign o_in_stall = i_q_full;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_byte     = i_in_item.header_byte;
    assign w_pos      = i_in_item.first_of_header ? '0 : r_idx;

    always_comb begin
        n_idx    = r_idx;
        n_magic  = r_magic;
        n_format = r_format;
        n_chan   = r_chan;
        n_rate   = r_rate;
        n_bits   = r_bits;
        n_size   = r_size;
        o_push   = '0;
        if (w_accept) begin
            if (i_in_item.stream_ended) begin
                if (r_idx < wavhp_pkg::HDR_END) begin
                    n_idx              = wavhp_pkg::HDR_END;
                    o_push.valid       = 1'b1;
                    o_push.job.status  = wavhp_pkg::ST_TRUNC;
                end
            end else if (i_in_item.first_of_header || r_idx < wavhp_pkg::HDR_END) begin
                n_magic = i_in_item.first_of_header ? 1'b1 : r_magic;
                case (w_pos) inside
                    [wavhp_pkg::OFS_RIFF:wavhp_pkg::OFS_RIFF+3]: begin
                        if (w_byte != wavhp_pkg::tag_byte(wavhp_pkg::RIFF_TAG, w_pos[1:0])) begin
                            n_magic = 1'b0;
                        end
                    end
                    [wavhp_pkg::OFS_WAVE:wavhp_pkg::OFS_WAVE+3]: begin
                        if (w_byte != wavhp_pkg::tag_byte(wavhp_pkg::WAVE_TAG, w_pos[1:0])) begin
                            n_magic = 1'b0;
                        end
                    end
                    [wavhp_pkg::OFS_FORMAT:wavhp_pkg::OFS_FORMAT+1]: begin
                        n_format[{w_pos[0], 3'b000} +: 8] = w_byte;
                    end
                    [wavhp_pkg::OFS_CHAN:wavhp_pkg::OFS_CHAN+1]: begin
                        n_chan[{w_pos[0], 3'b000} +: 8] = w_byte;
                    end
                    [wavhp_pkg::OFS_RATE:wavhp_pkg::OFS_RATE+3]: begin
                        n_rate[{w_pos[1:0], 3'b000} +: 8] = w_byte;
                    end
                    [wavhp_pkg::OFS_BITS:wavhp_pkg::OFS_BITS+1]: begin
                        n_bits[{w_pos[0], 3'b000} +: 8] = w_byte;
                    end
                    [wavhp_pkg::OFS_SIZE:wavhp_pkg::OFS_SIZE+3]: begin
                        n_size[{w_pos[1:0], 3'b000} +: 8] = w_byte;
                    end
                    default: ;
                endcase
                n_idx = w_pos + 1'b1;
                if (w_pos == wavhp_pkg::LAST_OFS) begin
                    o_push.valid        = 1'b1;
                    o_push.job.channels = n_chan;
                    o_push.job.rate     = n_rate;
                    o_push.job.bits     = n_bits;
                    o_push.job.size     = n_size;
                    // bad magic outranks a non-PCM format
                    if (!n_magic) begin
                        o_push.job.status = wavhp_pkg::ST_BAD_MAGIC;
                    end else if (n_format != wavhp_pkg::PCM_FORMAT) begin
                        o_push.job.status = wavhp_pkg::ST_NOT_PCM;
                    end else begin
                        o_push.job.status = wavhp_pkg::ST_OK;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_magic  <= 1'b1;
            r_format <= '0;
            r_chan   <= '0;
            r_rate   <= '0;
            r_bits   <= '0;
            r_size   <= '0;
        end else begin
            r_idx    <= n_idx;
            r_magic  <= n_magic;
            r_format <= n_format;
            r_chan   <= n_chan;
            r_rate   <= n_rate;
            r_bits   <= n_bits;
            r_size   <= n_size;
        end
    end

endmodule

// File: rtl/wavhp_back.sv
// Arithmetic back: byte rate by two registered multiplies, duration by a
// bit-serial restoring divider, result held in an output register.
// Depends on wavhp_pkg and wav_header_parser_assert.svh.
`include "wav_header_parser_assert.svh"

module wavhp_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  wavhp_pkg::t_job      i_head,
    input  logic                 i_q_empty,
    output logic                 o_pop,
    output logic                 o_out_valid,
    output wavhp_pkg::t_out_item o_out_item,
    input  logic                 i_out_stall
);

    wavhp_pkg::t_back_state          r_state;
    wavhp_pkg::t_back_state          n_state;
    wavhp_pkg::t_job                 r_job;
    logic [31:0]                     r_prod;
    logic [31:0]                     r_brate;
    logic [31:0]                     r_rem;
    logic [wavhp_pkg::SCALED_W-1:0]  r_quo;
    logic [wavhp_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                            r_out_valid;
    wavhp_pkg::t_out_item            r_out;
    wavhp_pkg::t_out_item            n_out;

    logic                            w_load;
    logic [47:0]                     w_mul1;
    logic [44:0]                     w_mul2;
    logic [wavhp_pkg::SCALED_W-1:0]  w_scaled;
    logic [32:0]                     w_trial;
    logic                            w_ge;

    localparam logic [wavhp_pkg::DIV_CNT_W-1:0] CNT_LAST =
        wavhp_pkg::DIV_CNT_W'(wavhp_pkg::DIV_STEPS - 1);

    assign w_mul1   = r_job.rate * r_job.channels;
    assign w_mul2   = r_prod * r_job.bits[15:3];
    assign w_scaled = r_job.size * wavhp_pkg::MS_PER_S;
    assign w_trial  = {r_rem, r_quo[wavhp_pkg::SCALED_W-1]};
    assign w_ge     = (w_trial >= {1'b0, r_brate});

    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        w_load  = 1'b0;
        unique case (r_state)
            wavhp_pkg::BK_IDLE: begin
                if (!i_q_empty) begin
                    o_pop   = 1'b1;
                    n_state = (i_head.status == wavhp_pkg::ST_OK) ? wavhp_pkg::BK_MUL1
                                                                  : wavhp_pkg::BK_DONE;
                end
            end
            wavhp_pkg::BK_MUL1: n_state = wavhp_pkg::BK_MUL2;
            wavhp_pkg::BK_MUL2: n_state = wavhp_pkg::BK_DIV;
            wavhp_pkg::BK_DIV: begin
                if (r_brate == '0 || r_cnt == CNT_LAST) begin
                    n_state = wavhp_pkg::BK_DONE;
                end
            end
            wavhp_pkg::BK_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    w_load  = 1'b1;
                    n_state = wavhp_pkg::BK_IDLE;
                end
            end
            default: n_state = wavhp_pkg::BK_IDLE;
        endcase
    end

    // Failed jobs report only the status; every other field stays zero
    always_comb begin
        n_out = '0;
        n_out.parse_status = r_job.status;
        if (r_job.status == wavhp_pkg::ST_OK) begin
            n_out.channel_count = r_job.channels;
            n_out.sample_hz     = r_job.rate;
            n_out.sample_bits   = r_job.bits;
            n_out.payload_bytes = r_job.size;
            n_out.byte_rate     = r_brate;
            n_out.duration_ms   = r_quo[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= wavhp_pkg::BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_head;
            r_cnt <= '0;
        end
        case (r_state)
            wavhp_pkg::BK_MUL1: begin
                r_prod <= w_mul1[31:0];
                r_quo  <= w_scaled;
                r_rem  <= '0;
            end
            wavhp_pkg::BK_MUL2: begin
                r_brate <= w_mul2[31:0];
            end
            wavhp_pkg::BK_DIV: begin
                if (r_brate == '0) begin
                    r_quo <= '0;
                end else begin
                    r_rem <= w_ge ? 32'(w_trial - {1'b0, r_brate}) : w_trial[31:0];
                    r_quo <= {r_quo[wavhp_pkg::SCALED_W-2:0], w_ge};
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            default: ;
        endcase
        if (w_load) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    `WAVHP_ASSERT_SAME(a_div_nonzero,
        (r_state == wavhp_pkg::BK_DIV) && (r_cnt != '0), r_brate != '0,
        "divide step with zero byte rate")
    `WAVHP_ASSERT_SAME(a_fail_zero,
        r_out_valid && (r_out.parse_status != wavhp_pkg::ST_OK),
        (r_out.byte_rate == '0) && (r_out.duration_ms == '0),
        "failed status with nonzero derived fields")
    `WAVHP_ASSERT_NEXT(a_pop_next, o_pop,
        (r_state == wavhp_pkg::BK_MUL1) || (r_state == wavhp_pkg::BK_DONE),
        "pop did not start a job")

endmodule

// File: rtl/wav_header_parser.sv
// WAV header parser top: 44-byte RIFF/WAVE header in, one status item out.
// Throughput: one header byte per cycle while the queue has room; the back handles an ok
// header in order: pop, BK_MUL1, BK_MUL2, 42 one-bit divide steps, load, so back-to-back
// headers stall the input once the 2-entry queue fills.
// A zero byte rate ends the divide early; failed headers skip the arithmetic.
// Reset (sync, active low) clears counters, queue and output valid.
module wav_header_parser (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // header byte items
    input  logic                 i_in_valid,
    input  wavhp_pkg::t_in_item  i_in_item,
    output logic                 o_in_stall,
    // result items
    output logic                 o_out_valid,
    output wavhp_pkg::t_out_item o_out_item,
    input  logic                 i_out_stall
);

    // front -> queue
    wavhp_pkg::t_qpush w_push;
    logic              w_q_full;
    // queue -> back
    wavhp_pkg::t_job   w_head;
    logic              w_q_empty;
    logic              w_pop;

    // Front: byte counting, magic check and field capture at full byte rate while the queue has room
    wavhp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_item  (i_in_item),
        .o_in_stall (o_in_stall),
        .i_q_full   (w_q_full),
        .o_push     (w_push)
    );

    // Decouples the byte stream from the slow back-end arithmetic
    wavhp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_empty (w_q_empty),
        .o_full  (w_q_full)
    );

    // Back: byte rate, duration and the output register
    wavhp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_head),
        .i_q_empty   (w_q_empty),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall)
    );

endmodule
